FILE: rtl/bwu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bwu_pkg;

  // Default number of block requests kept in flight.
  localparam int WINDOW_DEFAULT = 1;

  // Event codes carried in the mode field.
  localparam logic [1:0] MODE_START    = 2'd0;
  localparam logic [1:0] MODE_RESPONSE = 2'd1;
  localparam logic [1:0] MODE_TIMEOUT  = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_BLOCK    = 2'd0;
  localparam logic [1:0] KIND_REJECT   = 2'd1;
  localparam logic [1:0] KIND_COMPLETE = 2'd2;
  localparam logic [1:0] KIND_FAIL     = 2'd3;

  // Reasons for rejecting a start request.
  localparam logic [1:0] REASON_ZERO_LENGTH = 2'd0;
  localparam logic [1:0] REASON_BUSY        = 2'd1;
  localparam logic [1:0] REASON_LINK_DOWN   = 2'd2;
  localparam logic [1:0] REASON_NO_SERVER   = 2'd3;

  // Response codes: 2.31 Continue and 2.04 Changed.
  localparam logic [7:0] CODE_CONTINUE = 8'd95;
  localparam logic [7:0] CODE_CHANGED  = 8'd68;

  // Block size exponent: reset value and largest meaningful value.
  localparam logic [2:0] EXP_RESET = 3'd6;
  localparam logic [2:0] EXP_MAX   = 3'd6;

  typedef struct packed {
    logic [1:0]  mode;
    logic [23:0] total_length;
    logic        link_ready;
    logic        server_available;
    logic [7:0]  response_code;
  } bwu_in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  reject_reason;
    logic [19:0] block_number;
    logic [23:0] byte_offset;
    logic [10:0] block_length;
    logic        more_blocks;
    logic        last;
  } bwu_out_t;

  // Work handed from the control stage to the result stage.
  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  reason;
    logic [19:0] first_block;
    logic [23:0] length;
    logic [2:0]  exponent;
  } bwu_job_t;

  // Clamp the exponent: values above six mean 1024-byte blocks.
  function automatic logic [2:0] clamp_exp(input logic [2:0] e);
    clamp_exp = (e > EXP_MAX) ? EXP_MAX : e;
  endfunction

  // Bit shift giving the block size, 16 << e.
  function automatic logic [3:0] block_shift(input logic [2:0] e);
    block_shift = {1'b0, e} + 4'd4;
  endfunction

  // Block size in bytes for an already clamped exponent.
  function automatic logic [10:0] block_bytes(input logic [2:0] e);
    block_bytes = 11'd16 << e;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/bwu_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module bwu_ctrl #(
  parameter int WINDOW = bwu_pkg::WINDOW_DEFAULT,
  localparam int CNT_W = $clog2(WINDOW + 1)
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                cfg_we,
  input  wire [2:0]          cfg_wdata,
  input  wire                accept,
  input  bwu_pkg::bwu_in_t   item,
  output logic               job_valid,
  output bwu_pkg::bwu_job_t  job,
  output logic [CNT_W-1:0]   job_cnt
);

  logic [2:0]  exp_r;
  logic        busy_r, busy_nxt;
  logic [23:0] len_r, len_nxt;
  logic [23:0] acked_off_r, acked_off_nxt;
  logic [20:0] acked_blk_r, acked_blk_nxt;
  logic [20:0] next_blk_r, next_blk_nxt;

  logic [2:0]       exp_eff;
  logic [3:0]       shift;
  logic [10:0]      bs;
  logic [23:0]      issue_len;
  logic [20:0]      issue_nb;
  logic [24:0]      round_sum;
  logic [20:0]      total;
  logic [20:0]      diff;
  logic [CNT_W-1:0] issue_cnt;
  logic [23:0]      rem_ack;
  logic [23:0]      step;
  logic [23:0]      acked_new;
  logic [20:0]      blk_new;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r <= bwu_pkg::EXP_RESET;
    end else if (cfg_we) begin
      exp_r <= cfg_wdata;
    end
  end

  // Block size for this step.
  assign exp_eff = bwu_pkg::clamp_exp(exp_r);
  assign shift   = bwu_pkg::block_shift(exp_eff);
  assign bs      = bwu_pkg::block_bytes(exp_eff);

  // Window sizing: a start issues from block zero, a continue from the next block.
  assign issue_len = (item.mode == bwu_pkg::MODE_START) ? item.total_length : len_r;
  assign issue_nb  = (item.mode == bwu_pkg::MODE_START) ? 21'd0 : next_blk_r;
  assign round_sum = {1'b0, issue_len} + 25'(bs) - 25'd1;
  assign total     = 21'(round_sum >> shift);
  assign diff      = total - issue_nb;

  always_comb begin
    if (total > issue_nb) begin
      issue_cnt = (diff > 21'(WINDOW)) ? CNT_W'(WINDOW) : diff[CNT_W-1:0];
    end else begin
      issue_cnt = '0;
    end
  end

  // Acknowledged position after a Continue.
  assign rem_ack   = len_r - acked_off_r;
  assign step      = (rem_ack > 24'(bs)) ? 24'(bs) : rem_ack;
  assign acked_new = acked_off_r + step;
  assign blk_new   = acked_blk_r + 21'd1;

  // Event handling and job generation.
  always_comb begin
    busy_nxt      = busy_r;
    len_nxt       = len_r;
    acked_off_nxt = acked_off_r;
    acked_blk_nxt = acked_blk_r;
    next_blk_nxt  = next_blk_r;
    job_valid     = 1'b0;
    job_cnt       = CNT_W'(1);
    job.kind        = bwu_pkg::KIND_BLOCK;
    job.reason      = bwu_pkg::REASON_ZERO_LENGTH;
    job.first_block = issue_nb[19:0];
    job.length      = issue_len;
    job.exponent    = exp_eff;

    if (accept) begin
      unique case (item.mode)
        bwu_pkg::MODE_START: begin
          job_valid = 1'b1;
          priority if (item.total_length == 24'd0) begin
            job.kind   = bwu_pkg::KIND_REJECT;
            job.reason = bwu_pkg::REASON_ZERO_LENGTH;
          end else if (busy_r) begin
            job.kind   = bwu_pkg::KIND_REJECT;
            job.reason = bwu_pkg::REASON_BUSY;
          end else if (!item.link_ready) begin
            job.kind   = bwu_pkg::KIND_REJECT;
            job.reason = bwu_pkg::REASON_LINK_DOWN;
          end else if (!item.server_available) begin
            job.kind   = bwu_pkg::KIND_REJECT;
            job.reason = bwu_pkg::REASON_NO_SERVER;
          end else begin
            busy_nxt      = 1'b1;
            len_nxt       = item.total_length;
            acked_off_nxt = 24'd0;
            acked_blk_nxt = 21'd0;
            next_blk_nxt  = 21'(issue_cnt);
            job_cnt       = issue_cnt;
            job_valid     = (issue_cnt != '0);
          end
        end
        bwu_pkg::MODE_RESPONSE: begin
          if (busy_r) begin
            priority if (item.response_code == bwu_pkg::CODE_CONTINUE) begin
              acked_off_nxt = acked_new;
              acked_blk_nxt = blk_new;
              if (acked_new < len_r) begin
                if (next_blk_r <= blk_new) begin
                  next_blk_nxt = next_blk_r + 21'(issue_cnt);
                  job_cnt      = issue_cnt;
                  job_valid    = (issue_cnt != '0);
                end
              end else begin
                busy_nxt      = 1'b0;
                len_nxt       = 24'd0;
                acked_off_nxt = 24'd0;
                acked_blk_nxt = 21'd0;
                next_blk_nxt  = 21'd0;
                job_valid     = 1'b1;
                job.kind      = bwu_pkg::KIND_COMPLETE;
              end
            end else if (item.response_code == bwu_pkg::CODE_CHANGED) begin
              busy_nxt      = 1'b0;
              len_nxt       = 24'd0;
              acked_off_nxt = 24'd0;
              acked_blk_nxt = 21'd0;
              next_blk_nxt  = 21'd0;
              job_valid     = 1'b1;
              job.kind      = bwu_pkg::KIND_COMPLETE;
            end else begin
              busy_nxt      = 1'b0;
              len_nxt       = 24'd0;
              acked_off_nxt = 24'd0;
              acked_blk_nxt = 21'd0;
              next_blk_nxt  = 21'd0;
              job_valid     = 1'b1;
              job.kind      = bwu_pkg::KIND_FAIL;
            end
          end
        end
        bwu_pkg::MODE_TIMEOUT: begin
          if (busy_r) begin
            busy_nxt      = 1'b0;
            len_nxt       = 24'd0;
            acked_off_nxt = 24'd0;
            acked_blk_nxt = 21'd0;
            next_blk_nxt  = 21'd0;
            job_valid     = 1'b1;
            job.kind      = bwu_pkg::KIND_FAIL;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Transfer state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      len_r       <= 24'd0;
      acked_off_r <= 24'd0;
      acked_blk_r <= 21'd0;
      next_blk_r  <= 21'd0;
    end else begin
      busy_r      <= busy_nxt;
      len_r       <= len_nxt;
      acked_off_r <= acked_off_nxt;
      acked_blk_r <= acked_blk_nxt;
      next_blk_r  <= next_blk_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/bwu_emit.sv
`timescale 1ns / 1ps
`default_nettype none

module bwu_emit #(
  parameter int WINDOW = bwu_pkg::WINDOW_DEFAULT,
  localparam int CNT_W = $clog2(WINDOW + 1)
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                job_valid,
  input  bwu_pkg::bwu_job_t  job,
  input  wire [CNT_W-1:0]    job_cnt,
  output logic               job_ready,
  output logic               out_valid,
  input  wire                out_ready,
  output bwu_pkg::bwu_out_t  out_data
);

  logic              pend_r, pend_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  bwu_pkg::bwu_job_t job_r;
  logic [19:0]       nb_r;
  logic              out_valid_r;
  bwu_pkg::bwu_out_t out_r;

  logic              out_free;
  logic              fire;
  logic              final_res;
  logic [3:0]        shift;
  logic [10:0]       bs;
  logic [23:0]       off;
  logic [23:0]       rem;
  bwu_pkg::bwu_out_t res;

  // One result leaves the job register per cycle when the output register is free.
  assign out_free  = !out_valid_r || out_ready;
  assign fire      = pend_r && out_free;
  assign final_res = (cnt_r == CNT_W'(1));
  assign job_ready = !pend_r || (fire && final_res);

  // Build the current result from the held job.
  assign shift = bwu_pkg::block_shift(job_r.exponent);
  assign bs    = bwu_pkg::block_bytes(job_r.exponent);
  assign off   = 24'(nb_r) << shift;
  assign rem   = job_r.length - off;

  always_comb begin
    res      = '0;
    res.kind = job_r.kind;
    res.last = final_res;
    if (job_r.kind == bwu_pkg::KIND_BLOCK) begin
      res.block_number = nb_r;
      res.byte_offset  = off;
      res.more_blocks  = (rem > 24'(bs));
      res.block_length = (rem > 24'(bs)) ? bs : rem[10:0];
    end else begin
      res.reject_reason = (job_r.kind == bwu_pkg::KIND_REJECT) ? job_r.reason
                                                                : bwu_pkg::REASON_ZERO_LENGTH;
    end
  end

  // Job bookkeeping.
  always_comb begin
    pend_nxt = pend_r;
    cnt_nxt  = cnt_r;
    if (job_valid) begin
      pend_nxt = 1'b1;
      cnt_nxt  = job_cnt;
    end else if (fire) begin
      pend_nxt = !final_res;
      cnt_nxt  = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      pend_r <= pend_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (job_valid) begin
      job_r <= job;
      nb_r  <= job.first_block;
    end else if (fire) begin
      nb_r  <= nb_r + 20'd1;
    end
  end

  // Output register: holds a result until its transfer completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= pend_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

FILE: rtl/blockwise_upload_sequencer_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Sender-side sequencer for a blockwise upload.
// Input channel (in_valid/in_ready/in_data) carries start, response and
// timeout events; the result channel (out_valid/out_ready/out_data) carries
// block requests, start rejections and completion or failure notices, with
// last set on the final result caused by each event.
// cfg_we/cfg_wdata write the block size exponent (16 << exponent bytes,
// values above six mean 1024); write it only while no event or result is in
// flight. An open upload uses the new size from its next event onwards.
// An event's work is registered in the job register and its results then
// pass through the output register. Each event occupies the job register
// while it emits its results, one per cycle while the output register is
// free, so with a window of one a new event is taken every cycle while the
// receiver keeps up. Events that produce no result never occupy the job
// register.
// When the receiver stalls, the output register holds its result and the
// job register fills behind it; in_ready then drops until a slot frees.
// Reset (synchronous, rst_n low) clears the transfer state, empties both
// registers and sets the exponent to six.
module blockwise_upload_sequencer_core #(
  parameter int WINDOW = bwu_pkg::WINDOW_DEFAULT
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               cfg_we,
  input  wire [2:0]         cfg_wdata,
  input  wire               in_valid,
  output logic              in_ready,
  input  bwu_pkg::bwu_in_t  in_data,
  output logic              out_valid,
  input  wire               out_ready,
  output bwu_pkg::bwu_out_t out_data
);

  localparam int CNT_W = $clog2(WINDOW + 1);

  logic              accept;
  logic              job_valid;
  logic              job_ready;
  bwu_pkg::bwu_job_t job;
  logic [CNT_W-1:0]  job_cnt;

  // An event is taken whenever the job register can take its work.
  assign in_ready = job_ready;
  assign accept   = in_valid && job_ready;

  bwu_ctrl #(
    .WINDOW (WINDOW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .item      (in_data),
    .job_valid (job_valid),
    .job       (job),
    .job_cnt   (job_cnt)
  );

  bwu_emit #(
    .WINDOW (WINDOW)
  ) u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job       (job),
    .job_cnt   (job_cnt),
    .job_ready (job_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // A new job always carries at least one result.
  assert property (@(posedge clk) disable iff (!rst_n)
    job_valid |-> (job_cnt != '0))
    else $error("job issued with no results");

  // Status jobs produce exactly one result.
  assert property (@(posedge clk) disable iff (!rst_n)
    (job_valid && (job.kind != bwu_pkg::KIND_BLOCK)) |-> (job_cnt == CNT_W'(1)))
    else $error("status job with more than one result");

  // Status results always close their event.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.kind != bwu_pkg::KIND_BLOCK)) |-> out_data.last)
    else $error("status result without last");

  // Block requests carry between one byte and one full block.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.kind == bwu_pkg::KIND_BLOCK)) |->
      ((out_data.block_length != 11'd0) && (out_data.block_length <= 11'd1024)))
    else $error("block request length out of range");

endmodule

`default_nettype wire

FILE: sim/tb_blockwise_upload_sequencer_core.sv
`timescale 1ns / 1ps

module tb_blockwise_upload_sequencer_core;

  // Mode 3 is unused by the block and must change nothing.
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int         WIN         = bwu_pkg::WINDOW_DEFAULT;
  localparam int         STALL_LIMIT = 2000;

  logic     clk;
  logic     rst_n     = 1'b0;
  logic     cfg_we    = 1'b0;
  logic [2:0] cfg_wdata = 3'd0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  bwu_pkg::bwu_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  bwu_pkg::bwu_out_t out_data;

  // Shadow of the block state, updated on every accepted event.
  logic [2:0]  size_exp   = bwu_pkg::EXP_RESET;
  logic        xfer_busy  = 1'b0;
  logic [23:0] xfer_len   = '0;
  logic [23:0] acked_off  = '0;
  logic [20:0] acked_blk  = '0;
  logic [20:0] next_blk   = '0;

  bwu_pkg::bwu_in_t  queued_events[$];
  bwu_pkg::bwu_out_t predicted_results[$];
  int       mismatches   = 0;
  int       quiet_cycles = 0;
  logic     steady_flow  = 1'b0;

  logic [2:0] phase_exp [8] = '{3'd0, 3'd7, 3'd3, 3'd6, 3'd1, 3'd5, 3'd2, 3'd4};

  blockwise_upload_sequencer_core #(
    .WINDOW(WIN)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Block size in bytes; exponents above six give 1024.
  function automatic int unsigned blk_bytes();
    logic [2:0] e;
    e = (size_exp > 3'd6) ? 3'd6 : size_exp;
    return 32'd16 << e;
  endfunction

  function automatic bwu_pkg::bwu_out_t notice(logic [1:0] k, logic [1:0] why);
    bwu_pkg::bwu_out_t r;
    r = '0;
    r.kind = k;
    r.reject_reason = why;
    return r;
  endfunction

  function automatic void drop_transfer();
    xfer_busy = 1'b0;
    xfer_len  = '0;
    acked_off = '0;
    acked_blk = '0;
    next_blk  = '0;
  endfunction

  // Issue the block requests that fit in the window from next_blk onwards.
  function automatic void open_window();
    int unsigned bs, blocks, nb, stop, off, rem, blen, issued;
    bwu_pkg::bwu_out_t r;
    bs = blk_bytes();
    blocks = (32'(xfer_len) + bs - 1) / bs;
    nb = 32'(next_blk);
    stop = nb + WIN;
    issued = 0;
    while (nb < stop && nb < blocks && issued < 8) begin
      off  = nb * bs;
      rem  = 32'(xfer_len) - off;
      blen = (rem > bs) ? bs : rem;
      r = notice(bwu_pkg::KIND_BLOCK, bwu_pkg::REASON_ZERO_LENGTH);
      r.block_number = nb[19:0];
      r.byte_offset  = off[23:0];
      r.block_length = blen[10:0];
      r.more_blocks  = (rem > blen);
      predicted_results.push_back(r);
      issued++;
      nb++;
    end
    next_blk = nb[20:0];
  endfunction

  // Work out the results of one accepted event and advance the shadow state.
  function automatic void predict_event(bwu_pkg::bwu_in_t ev);
    int          base;
    int unsigned bs, rem, stride;
    bwu_pkg::bwu_out_t tail;
    base = predicted_results.size();
    case (ev.mode)
      bwu_pkg::MODE_START: begin
        if (ev.total_length == 24'd0) begin
          predicted_results.push_back(notice(bwu_pkg::KIND_REJECT,
                                             bwu_pkg::REASON_ZERO_LENGTH));
        end else if (xfer_busy) begin
          predicted_results.push_back(notice(bwu_pkg::KIND_REJECT, bwu_pkg::REASON_BUSY));
        end else if (!ev.link_ready) begin
          predicted_results.push_back(notice(bwu_pkg::KIND_REJECT,
                                             bwu_pkg::REASON_LINK_DOWN));
        end else if (!ev.server_available) begin
          predicted_results.push_back(notice(bwu_pkg::KIND_REJECT,
                                             bwu_pkg::REASON_NO_SERVER));
        end else begin
          drop_transfer();
          xfer_busy = 1'b1;
          xfer_len  = ev.total_length;
          open_window();
        end
      end
      bwu_pkg::MODE_RESPONSE: begin
        if (xfer_busy) begin
          if (ev.response_code == bwu_pkg::CODE_CONTINUE) begin
            bs = blk_bytes();
            rem = 32'(xfer_len) - 32'(acked_off);
            stride = (rem > bs) ? bs : rem;
            acked_off = acked_off + stride[23:0];
            acked_blk = acked_blk + 21'd1;
            if (acked_off < xfer_len) begin
              if (next_blk <= acked_blk) open_window();
            end else begin
              drop_transfer();
              predicted_results.push_back(notice(bwu_pkg::KIND_COMPLETE,
                                                 bwu_pkg::REASON_ZERO_LENGTH));
            end
          end else if (ev.response_code == bwu_pkg::CODE_CHANGED) begin
            drop_transfer();
            predicted_results.push_back(notice(bwu_pkg::KIND_COMPLETE,
                                               bwu_pkg::REASON_ZERO_LENGTH));
          end else begin
            drop_transfer();
            predicted_results.push_back(notice(bwu_pkg::KIND_FAIL,
                                               bwu_pkg::REASON_ZERO_LENGTH));
          end
        end
      end
      bwu_pkg::MODE_TIMEOUT: begin
        if (xfer_busy) begin
          drop_transfer();
          predicted_results.push_back(notice(bwu_pkg::KIND_FAIL,
                                             bwu_pkg::REASON_ZERO_LENGTH));
        end
      end
      default: ;
    endcase
    // The final result of the event carries the last flag.
    if (predicted_results.size() > base) begin
      tail = predicted_results.pop_back();
      tail.last = 1'b1;
      predicted_results.push_back(tail);
    end
  endfunction

  function automatic void push_event(logic [1:0] m, logic [23:0] tl, logic rdy, logic srv,
                                     logic [7:0] code);
    bwu_pkg::bwu_in_t ev;
    ev.mode             = m;
    ev.total_length     = tl;
    ev.link_ready       = rdy;
    ev.server_available = srv;
    ev.response_code    = code;
    queued_events.push_back(ev);
  endfunction

  // Responses and timeouts carry random values in the fields they do not use.
  function automatic void push_response(logic [7:0] code);
    push_event(bwu_pkg::MODE_RESPONSE, 24'($urandom), 1'($urandom), 1'($urandom), code);
  endfunction

  function automatic void push_timeout();
    push_event(bwu_pkg::MODE_TIMEOUT, 24'($urandom), 1'($urandom), 1'($urandom),
               8'($urandom));
  endfunction

  function automatic logic [7:0] failing_code();
    logic [7:0] c;
    c = 8'($urandom);
    if (c == bwu_pkg::CODE_CONTINUE || c == bwu_pkg::CODE_CHANGED) c = c + 8'd1;
    return c;
  endfunction

  // Noise while no transfer is open; returns the number of events that give a result.
  function automatic int idle_noise();
    logic [1:0] flags;
    flags = 2'($urandom_range(0, 2));
    case ($urandom_range(0, 3))
      0: begin
        push_response(8'($urandom));
        return 0;
      end
      1: begin
        push_timeout();
        return 0;
      end
      2: begin
        push_event(bwu_pkg::MODE_START, 24'($urandom_range(1, 24'hFFFFFF)), flags[1],
                   flags[0], 8'($urandom));
        return 1;
      end
      default: begin
        push_event(bwu_pkg::MODE_START, 24'd0, 1'($urandom), 1'($urandom), 8'($urandom));
        return 1;
      end
    endcase
  endfunction

  // Noise inside an open transfer: rejected starts and the unused mode.
  function automatic int busy_noise();
    case ($urandom_range(0, 2))
      0: begin
        push_event(bwu_pkg::MODE_START, 24'($urandom_range(1, 24'hFFFFFF)), 1'($urandom),
                   1'($urandom), 8'($urandom));
        return 1;
      end
      1: begin
        push_event(bwu_pkg::MODE_START, 24'd0, 1'($urandom), 1'($urandom), 8'($urandom));
        return 1;
      end
      default: begin
        push_event(MODE_UNUSED, 24'($urandom), 1'($urandom), 1'($urandom), 8'($urandom));
        return 0;
      end
    endcase
  endfunction

  // One upload: a start, its Continue acknowledgements, and now and then an early
  // Changed, a failing code or a timeout part way through.
  function automatic int add_upload(int unsigned bs);
    int unsigned blocks, cut, style, pick;
    logic [23:0] len;
    int          n;
    pick  = $urandom_range(0, 9);
    style = $urandom_range(0, 9);
    case (pick)
      0: len = 24'(bs * $urandom_range(1, 4));
      1: len = 24'($urandom_range(1, bs));
      2: begin
        len = 24'($urandom);
        if (len == 24'd0) len = 24'd1;
        if (style < 7) style = $urandom_range(7, 9);
      end
      default: len = 24'($urandom_range(1, 5 * bs));
    endcase
    blocks = (32'(len) + bs - 1) / bs;
    cut = (style < 7) ? blocks : $urandom_range(0, (blocks > 5) ? 4 : blocks - 1);
    push_event(bwu_pkg::MODE_START, len, 1'b1, 1'b1, 8'($urandom));
    n = 1;
    for (int unsigned i = 0; i < cut; i++) begin
      if ($urandom_range(0, 99) < 12) n += busy_noise();
      push_response(bwu_pkg::CODE_CONTINUE);
      n++;
    end
    case (style)
      7: push_response(bwu_pkg::CODE_CHANGED);
      8: push_response(failing_code());
      9: push_timeout();
      default: ;
    endcase
    if (style >= 7) n++;
    return n;
  endfunction

  // Wait until every event has been taken and every result has come back.
  task automatic wait_idle();
    do @(negedge clk);
    while (queued_events.size() != 0 || in_valid || predicted_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_exponent(logic [2:0] e);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= e;
    @(posedge clk);
    cfg_we    <= 1'b0;
    size_exp = e;
  endtask

  // Event driver: offers the next queued event once the previous transfer is done.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) predict_event(in_data);
      if (queued_events.size() != 0 && (steady_flow || $urandom_range(0, 99) >= 37)) begin
        in_valid <= 1'b1;
        in_data  <= queued_events.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result monitor: compares each result transfer with the oldest prediction.
  always @(posedge clk) begin : result_monitor
    bwu_pkg::bwu_out_t want;
    out_ready <= steady_flow || ($urandom_range(0, 99) >= 37);
    if (rst_n && out_valid && out_ready) begin
      if (predicted_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result: kind=%0d reason=%0d num=%0d off=%0d len=%0d",
                   out_data.kind, out_data.reject_reason, out_data.block_number,
                   out_data.byte_offset, out_data.block_length);
      end else begin
        want = predicted_results.pop_front();
        if (out_data.kind !== want.kind || out_data.reject_reason !== want.reject_reason ||
            out_data.block_number !== want.block_number ||
            out_data.byte_offset !== want.byte_offset ||
            out_data.block_length !== want.block_length ||
            out_data.more_blocks !== want.more_blocks || out_data.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Mismatch: expected kind=%0d reason=%0d num=%0d off=%0d len=%0d more=%0d last=%0d",
                     want.kind, want.reject_reason, want.block_number, want.byte_offset,
                     want.block_length, want.more_blocks, want.last);
            $display("          actual   kind=%0d reason=%0d num=%0d off=%0d len=%0d more=%0d last=%0d",
                     out_data.kind, out_data.reject_reason, out_data.block_number,
                     out_data.byte_offset, out_data.block_length, out_data.more_blocks,
                     out_data.last);
          end
        end
      end
    end
  end

  // Watchdog: ends the run when no transfer happens on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned bs;
    int          produced;
    logic [2:0]  e;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part at the reset block size of 1024 bytes.
    push_response(bwu_pkg::CODE_CONTINUE);
    push_timeout();
    push_event(MODE_UNUSED, 24'hFFFFFF, 1'b1, 1'b1, 8'hFF);
    push_event(bwu_pkg::MODE_START, 24'd0, 1'b0, 1'b0, 8'h00);
    push_event(bwu_pkg::MODE_START, 24'd100, 1'b0, 1'b0, 8'h00);
    push_event(bwu_pkg::MODE_START, 24'd100, 1'b1, 1'b0, 8'h00);
    push_event(bwu_pkg::MODE_START, 24'hFFFFFF, 1'b1, 1'b1, 8'hFF);
    push_event(bwu_pkg::MODE_START, 24'd5, 1'b0, 1'b0, 8'h00);
    push_response(bwu_pkg::CODE_CONTINUE);
    push_response(bwu_pkg::CODE_CONTINUE);
    push_response(8'hFF);
    push_event(bwu_pkg::MODE_START, 24'd1, 1'b1, 1'b1, 8'h00);
    push_response(bwu_pkg::CODE_CONTINUE);
    push_event(bwu_pkg::MODE_START, 24'd2048, 1'b1, 1'b1, 8'h00);
    push_response(bwu_pkg::CODE_CONTINUE);
    push_response(bwu_pkg::CODE_CONTINUE);
    push_event(bwu_pkg::MODE_START, 24'd3000, 1'b1, 1'b1, 8'h00);
    push_response(bwu_pkg::CODE_CHANGED);
    push_event(bwu_pkg::MODE_START, 24'd700, 1'b1, 1'b1, 8'h00);
    push_response(8'h00);
    push_event(bwu_pkg::MODE_START, 24'd1024, 1'b1, 1'b1, 8'h00);
    push_event(MODE_UNUSED, 24'd0, 1'b0, 1'b0, 8'h00);
    push_timeout();
    // Left open so that the block size changes in the middle of this upload.
    push_event(bwu_pkg::MODE_START, 24'd5000, 1'b1, 1'b1, 8'h00);

    // Random phases, each with its own size exponent.
    for (int p = 0; p < 8; p++) begin
      wait_idle();
      e = phase_exp[p];
      write_exponent(e);
      @(negedge clk);
      steady_flow = (p == 3);
      bs = 32'd16 << ((e > 3'd6) ? 3'd6 : e);
      produced = 0;
      if (p == 0) begin
        push_response(bwu_pkg::CODE_CONTINUE);
        push_response(bwu_pkg::CODE_CONTINUE);
        push_timeout();
        produced = 3;
      end
      while (produced < 26) begin
        if ($urandom_range(0, 99) < 20) produced += idle_noise();
        produced += add_upload(bs);
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/bwu_pkg.sv
rtl/bwu_ctrl.sv
rtl/bwu_emit.sv
rtl/blockwise_upload_sequencer_core.sv
sim/tb_blockwise_upload_sequencer_core.sv
